// File: src/router_node_congestion_cost_top_assert.svh
// Assertion macros for the router node congestion cost block.
// Used by router_node_congestion_cost_top; no other dependencies.
`ifndef ROUTER_NODE_CONGESTION_COST_TOP_ASSERT_SVH
`define ROUTER_NODE_CONGESTION_COST_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RNCC_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("rncc assertion failed");
`define RNCC_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("rncc assertion failed");
`else
`define RNCC_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define RNCC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: src/rncc_pkg.sv
// Shared types and constants for the router node congestion cost block.
// No dependencies.
`timescale 1ns / 1ps
package rncc_pkg;
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CONG_WEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_FACTOR = 8'd1;
  localparam logic [15:0] CONG_WEIGHT_RST = 16'd256;
  localparam logic [15:0] BIAS_FACTOR_RST = 16'd0;
  localparam logic [23:0] COST_MAX = 24'hFFFFFF;
  localparam int QUO_W = 40;
  localparam int MAIN_DEN_W = 9;
  localparam int BIAS_DEN_W = 27;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] hist;
    logic [8:0]  over;
    logic [10:0] mdist;
    logic [10:0] span;
    logic [15:0] fanout;
    logic [8:0]  div_m;
  } fe_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;
endpackage

// File: src/rncc_front.sv
// Front end: accepts items, clamps coordinates and classifies over-capacity.
// Depends on rncc_pkg.
`timescale 1ns / 1ps
module rncc_front import rncc_pkg::*; #(
  parameter int GRID_SIZE = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [9:0] node_x,
  input  logic [9:0] node_y,
  input  logic [9:0] center_x,
  input  logic [9:0] center_y,
  input  logic [10:0] net_span,
  input  logic [15:0] net_fanout,
  input  logic [15:0] node_base,
  input  logic [7:0] channel_width,
  input  logic [15:0] node_hist,
  input  logic [7:0] bound_count,
  input  logic [7:0] own_uses,
  input  fifo_stat_t q_stat,
  output logic       push,
  output fe_item_t   item_r,
  output logic       hold
);
  localparam logic [16:0] LIM = 17'(GRID_SIZE - 1);

  logic       vld_r, vld_nxt;
  fe_item_t   item_nxt;
  logic [9:0] nx, ny, cx, cy, dx, dy, ov;

  function automatic logic [9:0] clamp(input logic [9:0] v);
    clamp = ({7'b0, v} > LIM) ? LIM[9:0] : v;
  endfunction

  assign hold = vld_r && q_stat.full;
  assign push = vld_r && !q_stat.full;

  always_comb begin
    nx = clamp(node_x);
    ny = clamp(node_y);
    cx = clamp(center_x);
    cy = clamp(center_y);
    dx = (nx > cx) ? nx - cx : cx - nx;
    dy = (ny > cy) ? ny - cy : cy - ny;
    ov = {2'b0, bound_count} + 10'd1 - {2'b0, channel_width} - {9'b0, |own_uses};
    item_nxt.base   = node_base;
    item_nxt.hist   = node_hist;
    item_nxt.over   = (!ov[9] && ov != 10'd0) ? ov[8:0] : 9'd0;
    item_nxt.mdist  = {1'b0, dx} + {1'b0, dy};
    item_nxt.span   = (net_span == 11'd0) ? 11'd1 : net_span;
    item_nxt.fanout = (net_fanout == 16'd0) ? 16'd1 : net_fanout;
    item_nxt.div_m  = {1'b0, own_uses} + 9'd1;
    vld_nxt = accept ? 1'b1 : (push ? 1'b0 : vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end
endmodule

// File: src/rncc_fifo.sv
// Two-entry queue between front end and back end.
// Depends on rncc_pkg.
`timescale 1ns / 1ps
module rncc_fifo import rncc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  fe_item_t   push_item,
  input  logic       pop,
  output fe_item_t   head,
  output fifo_stat_t stat
);
  fe_item_t   mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;
  assign head = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end
endmodule

// File: src/rncc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// No package dependencies.
`timescale 1ns / 1ps
module rncc_div #(
  parameter int NW = 40,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          out_vld,
  output logic [NW-1:0] quo
);
  localparam int W = DW + NW;

  logic [W-1:0]  acc_r   [NW];
  logic [DW-1:0] den_r   [NW];
  logic          vld_r   [NW];
  logic [W-1:0]  acc_src [NW];
  logic [DW-1:0] den_src [NW];
  logic          vld_src [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [W:0]    sh;
    logic [DW:0]   hi, hi_n;
    logic          ge;
    logic [W-1:0]  acc_nxt;

    if (k == 0) begin : g_first
      assign acc_src[k] = {{DW{1'b0}}, num};
      assign den_src[k] = den;
      assign vld_src[k] = in_vld;
    end else begin : g_rest
      assign acc_src[k] = acc_r[k-1];
      assign den_src[k] = den_r[k-1];
      assign vld_src[k] = vld_r[k-1];
    end

    always_comb begin
      sh      = {acc_src[k], 1'b0};
      hi      = sh[W:NW];
      ge      = (hi >= {1'b0, den_src[k]});
      hi_n    = ge ? hi - {1'b0, den_src[k]} : hi;
      acc_nxt = {hi_n[DW-1:0], sh[NW-1:1], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_src[k];
      end
    end

    always_ff @(posedge clk) begin
      acc_r[k] <= acc_nxt;
      den_r[k] <= den_src[k];
    end
  end

  assign out_vld = vld_r[NW-1];
  assign quo     = acc_r[NW-1][NW-1:0];
endmodule

// File: src/rncc_back.sv
// Back end: multiplies out the cost terms, divides, sums and saturates.
// Depends on rncc_pkg and rncc_div.
`timescale 1ns / 1ps
module rncc_back import rncc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_stat_t q_stat,
  input  fe_item_t   head,
  input  logic [15:0] cong_weight,
  input  logic [15:0] bias_factor,
  output logic       pop,
  output logic       strobe_r,
  output logic [23:0] cost_r,
  output logic       sat_r
);
  // stage 1
  logic        s1_vld_r;
  logic [31:0] s1_bh_r, s1_fb_r;
  logic [24:0] s1_ow_r;
  logic [26:0] s1_fs_r;
  logic [10:0] s1_dist_r;
  logic [8:0]  s1_dm_r;
  // stage 2
  logic        s2_vld_r;
  logic [31:0] s2_bh_r;
  logic [24:0] s2_pres_r;
  logic [42:0] s2_n_r;
  logic [26:0] s2_fs_r;
  logic [8:0]  s2_dm_r;
  // stage 3
  logic        s3_vld_r;
  logic [56:0] s3_m_r;
  logic [42:0] s3_n_r;
  logic [26:0] s3_fs_r;
  logic [8:0]  s3_dm_r;

  logic              vm, vb, sum_vld;
  logic [QUO_W-1:0]  qm, qb;
  logic [QUO_W:0]    sum;
  logic              sum_sat;

  assign pop = !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= pop;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_bh_r   <= 32'(head.base) * 32'(head.hist);
    s1_fb_r   <= 32'(bias_factor) * 32'(head.base);
    s1_ow_r   <= 25'(head.over) * 25'(cong_weight);
    s1_fs_r   <= 27'(head.fanout) * 27'(head.span);
    s1_dist_r <= head.mdist;
    s1_dm_r   <= head.div_m;

    s2_bh_r   <= s1_bh_r;
    s2_pres_r <= 25'd256 + s1_ow_r;
    s2_n_r    <= 43'(s1_fb_r) * 43'(s1_dist_r);
    s2_fs_r   <= s1_fs_r;
    s2_dm_r   <= s1_dm_r;

    s3_m_r    <= 57'(s2_bh_r) * 57'(s2_pres_r);
    s3_n_r    <= s2_n_r;
    s3_fs_r   <= s2_fs_r;
    s3_dm_r   <= s2_dm_r;
  end

  // Drop the fraction bits ahead of division; nested floors match one floor.
  rncc_div #(.NW(QUO_W), .DW(MAIN_DEN_W)) u_div_main (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s3_vld_r),
    .num     (s3_m_r[55:16]),
    .den     (s3_dm_r),
    .out_vld (vm),
    .quo     (qm)
  );

  rncc_div #(.NW(QUO_W), .DW(BIAS_DEN_W)) u_div_bias (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s3_vld_r),
    .num     ({5'b0, s3_n_r[42:8]}),
    .den     (s3_fs_r),
    .out_vld (vb),
    .quo     (qb)
  );

  always_comb begin
    sum_vld = vm && vb;
    sum     = {1'b0, qm} + {1'b0, qb};
    sum_sat = |sum[QUO_W:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    cost_r <= sum_sat ? COST_MAX : sum[23:0];
    sat_r  <= sum_sat;
  end
endmodule

// File: src/router_node_congestion_cost_top.sv
// Node cost for negotiated-congestion routing: one item in, one cost out.
// Path: front-end item register, two-entry queue, back-end multiply stages and the 40-stage
// pipelined dividers in the back end, then the output register.
// Throughput: one item per cycle; busy stays low since the back end never stalls.
// Reset: synchronous active-low rst_n clears all valids and loads register defaults.
// Depends on rncc_pkg, rncc_front, rncc_fifo, rncc_back and the assertion header.
`timescale 1ns / 1ps
`include "router_node_congestion_cost_top_assert.svh"
module router_node_congestion_cost_top import rncc_pkg::*; #(
  parameter int GRID_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  in_node_x,
  input  logic [9:0]  in_node_y,
  input  logic [9:0]  in_center_x,
  input  logic [9:0]  in_center_y,
  input  logic [10:0] in_net_span,
  input  logic [15:0] in_net_fanout,
  input  logic [15:0] in_node_base,
  input  logic [7:0]  in_channel_width,
  input  logic [15:0] in_node_hist,
  input  logic [7:0]  in_bound_count,
  input  logic [7:0]  in_own_uses,
  output logic        out_strobe,
  output logic [23:0] out_node_cost,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] cong_weight_r, bias_factor_r;
  logic        accept, push, hold, pop;
  fe_item_t    fe_item, head;
  fifo_stat_t  q_stat;

  assign cfg_ready = 1'b1;
  assign busy      = hold;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cong_weight_r <= CONG_WEIGHT_RST;
      bias_factor_r <= BIAS_FACTOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONG_WEIGHT: cong_weight_r <= cfg_data;
        CFG_BIAS_FACTOR: bias_factor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rncc_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .node_x        (in_node_x),
    .node_y        (in_node_y),
    .center_x      (in_center_x),
    .center_y      (in_center_y),
    .net_span      (in_net_span),
    .net_fanout    (in_net_fanout),
    .node_base     (in_node_base),
    .channel_width (in_channel_width),
    .node_hist     (in_node_hist),
    .bound_count   (in_bound_count),
    .own_uses      (in_own_uses),
    .q_stat        (q_stat),
    .push          (push),
    .item_r        (fe_item),
    .hold          (hold)
  );

  rncc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (fe_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  rncc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .head        (head),
    .cong_weight (cong_weight_r),
    .bias_factor (bias_factor_r),
    .pop         (pop),
    .strobe_r    (out_strobe),
    .cost_r      (out_node_cost),
    .sat_r       (out_saturated)
  );

  `RNCC_ASSERT_IMPLIES(a_sat_max, clk, rst_n, out_strobe && out_saturated, out_node_cost == COST_MAX)
  `RNCC_ASSERT_IMPLIES(a_never_busy, clk, rst_n, 1'b1, !busy)
  `RNCC_ASSERT_NEXT(a_pop_drains, clk, rst_n, q_stat.full, !q_stat.full)
endmodule
